[rtl/core/pmst_pkg.sv]
// Shared types, field widths, constants and microcode for the spanning tree unit.
`timescale 1ns / 1ps

package pmst_pkg;

    localparam int VTX_W = 4;
    localparam int WGT_W = 10;
    localparam int TOT_W = 14;
    localparam int CNT_W = 5;
    localparam int KIND_W = 2;

    localparam logic [WGT_W-1:0] NO_EDGE = 10'd999;
    localparam logic [TOT_W-1:0] SCAN_START = 14'd9999;
    localparam logic [TOT_W-1:0] TOTAL_MAX = 14'd16383;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RUN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_CLEAR,
        OP_RUN_INIT,
        OP_ROUND_INIT,
        OP_READ,
        OP_CMP,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_DISPATCH,
        C_SWEEP_MORE,
        C_N_SMALL,
        C_SCAN_MORE,
        C_OUT_BUSY,
        C_STEP_MORE
    } cond_t;

    typedef logic [3:0] uaddr_t;

    localparam uaddr_t ST_WAIT = 4'd0;
    localparam uaddr_t ST_CLEAR = 4'd1;
    localparam uaddr_t ST_CLEAR_END = 4'd2;
    localparam uaddr_t ST_RUN = 4'd3;
    localparam uaddr_t ST_ROUND = 4'd4;
    localparam uaddr_t ST_READ = 4'd5;
    localparam uaddr_t ST_CMP = 4'd6;
    localparam uaddr_t ST_EMIT = 4'd7;
    localparam uaddr_t ST_LOOP = 4'd8;
    localparam uaddr_t ST_RUN_END = 4'd9;

    typedef struct packed {
        op_t    op;
        cond_t  cond;
        uaddr_t target;
    } uword_t;

    typedef struct packed {
        logic              in_beat;
        logic [KIND_W-1:0] in_kind;
        logic              sweep_more;
        logic              n_small;
        logic              scan_more;
        logic              out_busy;
        logic              step_more;
    } status_t;

    function automatic uword_t ucode(input uaddr_t addr);
        uword_t w;
        case (addr)
            ST_WAIT:      w = '{op: OP_ACCEPT,     cond: C_DISPATCH,   target: ST_WAIT};
            ST_CLEAR:     w = '{op: OP_CLEAR,      cond: C_SWEEP_MORE, target: ST_CLEAR};
            ST_CLEAR_END: w = '{op: OP_NOP,        cond: C_ALWAYS,     target: ST_WAIT};
            ST_RUN:       w = '{op: OP_RUN_INIT,   cond: C_N_SMALL,    target: ST_WAIT};
            ST_ROUND:     w = '{op: OP_ROUND_INIT, cond: C_NEVER,      target: ST_WAIT};
            ST_READ:      w = '{op: OP_READ,       cond: C_NEVER,      target: ST_WAIT};
            ST_CMP:       w = '{op: OP_CMP,        cond: C_SCAN_MORE,  target: ST_READ};
            ST_EMIT:      w = '{op: OP_EMIT,       cond: C_OUT_BUSY,   target: ST_EMIT};
            ST_LOOP:      w = '{op: OP_NOP,        cond: C_STEP_MORE,  target: ST_ROUND};
            ST_RUN_END:   w = '{op: OP_NOP,        cond: C_ALWAYS,     target: ST_WAIT};
            default:      w = '{op: OP_NOP,        cond: C_ALWAYS,     target: ST_WAIT};
        endcase
        return w;
    endfunction

endpackage

[rtl/core/prim_minimum_spanning_tree_unit.sv]
// Top level of the minimum spanning tree unit: config register, sequencer, datapath.
`timescale 1ns / 1ps

// Builds a minimum spanning tree by Prim's method over a symmetric weight matrix of
// MAX_VERTICES x MAX_VERTICES entries held in one RAM (one triangle used, one read and one
// write port). Input beats carry a kind in s_tuser: write edge (one beat per cycle), run,
// or clear. After reset and after each clear beat a clearing pass writes the no-edge weight
// 999 to all MAX_VERTICES^2 entries, one per cycle, and s_tready stays low until the pass
// and its end step are over. A run with n vertices in use (vertex_count, capped at
// MAX_VERTICES) emits n-1 edge beats (none for n below 2), the last one with m_tlast set;
// each tree edge is found by a full n x n scan through the single RAM read port, with a
// read step and a compare step per entry. Output back-pressure stalls the run only when
// the one-deep output register is still full. Write vertex_count only while the unit is idle.
module prim_minimum_spanning_tree_unit
    import pmst_pkg::*;
#(
    parameter int MAX_VERTICES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,   // vertex_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // vertex_a[3:0], vertex_b[7:4], weight[17:8], zero pad
    input  logic [1:0]  s_tuser,    // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // from_vertex[3:0], to_vertex[7:4], edge_weight[17:8],
                                    // running_total[31:18]
    output logic        m_tlast     // last
);

    logic [CNT_W-1:0] vertex_count_reg;
    op_t              op;
    status_t          status;
    logic [VTX_W-1:0] out_from;
    logic [VTX_W-1:0] out_to;
    logic [WGT_W-1:0] out_weight;
    logic [TOT_W-1:0] out_total;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= 5'd1;
        end
        else if (cfg_valid)
        begin
            vertex_count_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready = (op == OP_ACCEPT);

    pmst_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .op     (op)
    );

    pmst_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .vertex_count (vertex_count_reg),
        .in_valid     (s_tvalid),
        .in_kind      (s_tuser),
        .in_a         (s_tdata[3:0]),
        .in_b         (s_tdata[7:4]),
        .in_weight    (s_tdata[17:8]),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_from     (out_from),
        .out_to       (out_to),
        .out_weight   (out_weight),
        .out_total    (out_total),
        .out_last     (m_tlast),
        .status       (status)
    );

    assign m_tdata = {out_total, out_weight, out_to, out_from};

    a_beat_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(op == OP_EMIT))
        else $error("output beat raised without an emit step");

    a_total_covers_edge: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[17:8] <= m_tdata[31:18]))
        else $error("running total below edge weight");

    a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == KIND_RUN)) |=> !s_tready)
        else $error("input taken right after a run beat");

endmodule

[rtl/core/pmst_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pmst_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/pmst_seq.sv]
// Microcode sequencer: step counter, control store and conditional jumps.
`timescale 1ns / 1ps

module pmst_seq
    import pmst_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output op_t     op
);

    uaddr_t step_reg;
    uaddr_t step_next;
    uword_t uw;
    logic   take;
    uaddr_t dispatch;

    assign uw = ucode(step_reg);

    always_comb
    begin
        dispatch = ST_WAIT;
        if (status.in_beat)
        begin
            if (status.in_kind == KIND_RUN)
            begin
                dispatch = ST_RUN;
            end
            else if (status.in_kind == KIND_CLEAR)
            begin
                dispatch = ST_CLEAR;
            end
        end
    end

    always_comb
    begin
        case (uw.cond)
            C_NEVER:      take = 1'b0;
            C_ALWAYS:     take = 1'b1;
            C_DISPATCH:   take = 1'b1;
            C_SWEEP_MORE: take = status.sweep_more;
            C_N_SMALL:    take = status.n_small;
            C_SCAN_MORE:  take = status.scan_more;
            C_OUT_BUSY:   take = status.out_busy;
            C_STEP_MORE:  take = status.step_more;
            default:      take = 1'b1;
        endcase
    end

    always_comb
    begin
        if (uw.cond == C_DISPATCH)
        begin
            step_next = dispatch;
        end
        else if (take)
        begin
            step_next = uw.target;
        end
        else
        begin
            step_next = step_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_CLEAR;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign op = uw.op;

endmodule

[rtl/core/pmst_datapath.sv]
// Datapath: weight matrix, tree bits, scan indexes, best-edge compare and output slot.
`timescale 1ns / 1ps

module pmst_datapath
    import pmst_pkg::*;
#(
    parameter int MAX_VERTICES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  op_t               op,
    input  logic [CNT_W-1:0]  vertex_count,
    input  logic              in_valid,
    input  logic [KIND_W-1:0] in_kind,
    input  logic [VTX_W-1:0]  in_a,
    input  logic [VTX_W-1:0]  in_b,
    input  logic [WGT_W-1:0]  in_weight,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [VTX_W-1:0]  out_from,
    output logic [VTX_W-1:0]  out_to,
    output logic [WGT_W-1:0]  out_weight,
    output logic [TOT_W-1:0]  out_total,
    output logic              out_last,
    output status_t           status
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int AW = $clog2(DEPTH);

    function automatic logic [AW-1:0] tri_addr(input logic [VW-1:0] x, input logic [VW-1:0] y);
        logic [VW-1:0] lo;
        logic [VW-1:0] hi;
        lo = (x < y) ? x : y;
        hi = (x < y) ? y : x;
        return AW'(lo) * AW'(MAX_VERTICES) + AW'(hi);
    endfunction

    logic [MAX_VERTICES-1:0] in_tree_reg, in_tree_next;
    logic [AW-1:0]           sweep_reg, sweep_next;
    logic [VW-1:0]           n_last_reg, n_last_next;
    logic [VW-1:0]           j_reg, j_next;
    logic [VW-1:0]           k_reg, k_next;
    logic [VW-1:0]           fv_reg, fv_next;
    logic [VW-1:0]           tv_reg, tv_next;
    logic [VW-1:0]           emit_reg, emit_next;
    logic [TOT_W-1:0]        best_reg, best_next;
    logic [TOT_W-1:0]        total_reg, total_next;
    logic                    out_valid_reg, out_valid_next;
    logic [VTX_W-1:0]        out_from_reg, out_to_reg;
    logic [WGT_W-1:0]        out_weight_reg;
    logic [TOT_W-1:0]        out_total_reg;
    logic                    out_last_reg;

    logic [NW-1:0]     n_clamp;
    logic              in_beat;
    logic              wr_ok;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WGT_W-1:0]  ram_wdata;
    logic [WGT_W-1:0]  ram_rdata;
    logic              sweep_last;
    logic              scan_last;
    logic              better;
    logic              out_busy;
    logic              emit_go;
    logic              emit_last;
    logic [TOT_W:0]    sum;
    logic [TOT_W-1:0]  sum_sat;

    assign n_clamp = (int'(vertex_count) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vertex_count);
    assign in_beat = in_valid && (op == OP_ACCEPT);
    assign wr_ok = (int'(in_a) < MAX_VERTICES) && (int'(in_b) < MAX_VERTICES);
    assign sweep_last = (sweep_reg == AW'(DEPTH - 1));
    assign scan_last = (j_reg == n_last_reg) && (k_reg == n_last_reg);
    assign better = in_tree_reg[j_reg] && !in_tree_reg[k_reg] && (TOT_W'(ram_rdata) < best_reg);
    assign out_busy = out_valid_reg && !out_ready;
    assign emit_go = (op == OP_EMIT) && !out_busy;
    assign emit_last = (VW'(emit_reg + 1'b1) == n_last_reg);
    assign sum = (TOT_W + 1)'(total_reg) + (TOT_W + 1)'(best_reg);
    assign sum_sat = (sum > (TOT_W + 1)'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOT_W-1:0];

    always_comb
    begin
        ram_we = 1'b0;
        ram_waddr = sweep_reg;
        ram_wdata = NO_EDGE;
        if (op == OP_CLEAR)
        begin
            ram_we = 1'b1;
        end
        else if (in_beat && (in_kind == KIND_WRITE) && wr_ok)
        begin
            ram_we = 1'b1;
            ram_waddr = tri_addr(VW'(in_a), VW'(in_b));
            ram_wdata = in_weight;
        end
    end

    pmst_ram #(
        .WIDTH (WGT_W),
        .DEPTH (DEPTH)
    ) u_matrix (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (op == OP_READ),
        .raddr (tri_addr(j_reg, k_reg)),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        in_tree_next = in_tree_reg;
        sweep_next = sweep_reg;
        n_last_next = n_last_reg;
        j_next = j_reg;
        k_next = k_reg;
        fv_next = fv_reg;
        tv_next = tv_reg;
        emit_next = emit_reg;
        best_next = best_reg;
        total_next = total_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (op)
            OP_CLEAR:
            begin
                sweep_next = sweep_last ? '0 : sweep_reg + 1'b1;
            end
            OP_RUN_INIT:
            begin
                in_tree_next = '0;
                in_tree_next[0] = 1'b1;
                total_next = '0;
                emit_next = '0;
                n_last_next = VW'(n_clamp - 1'b1);
            end
            OP_ROUND_INIT:
            begin
                best_next = SCAN_START;
                j_next = '0;
                k_next = '0;
                fv_next = '0;
                tv_next = '0;
            end
            OP_CMP:
            begin
                if (better)
                begin
                    best_next = TOT_W'(ram_rdata);
                    fv_next = j_reg;
                    tv_next = k_reg;
                end
                if (k_reg == n_last_reg)
                begin
                    k_next = '0;
                    j_next = j_reg + 1'b1;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            OP_EMIT:
            begin
                if (emit_go)
                begin
                    in_tree_next[tv_reg] = 1'b1;
                    total_next = sum_sat;
                    emit_next = emit_reg + 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_tree_reg <= '0;
            sweep_reg <= '0;
            n_last_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
            emit_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_tree_reg <= in_tree_next;
            sweep_reg <= sweep_next;
            n_last_reg <= n_last_next;
            j_reg <= j_next;
            k_reg <= k_next;
            emit_reg <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fv_reg <= fv_next;
        tv_reg <= tv_next;
        best_reg <= best_next;
        total_reg <= total_next;
        if (emit_go)
        begin
            out_from_reg <= VTX_W'(fv_reg);
            out_to_reg <= VTX_W'(tv_reg);
            out_weight_reg <= best_reg[WGT_W-1:0];
            out_total_reg <= sum_sat;
            out_last_reg <= emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_from = out_from_reg;
    assign out_to = out_to_reg;
    assign out_weight = out_weight_reg;
    assign out_total = out_total_reg;
    assign out_last = out_last_reg;

    assign status.in_beat = in_beat;
    assign status.in_kind = in_kind;
    assign status.sweep_more = !sweep_last;
    assign status.n_small = (n_clamp < NW'(2));
    assign status.scan_more = !scan_last;
    assign status.out_busy = out_busy;
    assign status.step_more = (emit_reg != n_last_reg);

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the Prim spanning tree unit: directed script, then random graphs.
`timescale 1ns / 1ps

module tb_top;
    import pmst_pkg::*;

    localparam int MAX_VTX = 16;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE_CYCLES = 300;
    localparam int RANDOM_ITEMS = 190;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef enum logic {
        ROW_BEAT,
        ROW_CFG
    } row_t;

    typedef struct packed {
        logic [VTX_W-1:0] from_v;
        logic [VTX_W-1:0] to_v;
        logic [WGT_W-1:0] wgt;
        logic [TOT_W-1:0] total;
        logic             last;
    } tree_edge_t;

    typedef struct packed {
        row_t              row;
        logic [KIND_W-1:0] kind;
        logic [VTX_W-1:0]  va;
        logic [VTX_W-1:0]  vb;
        logic [WGT_W-1:0]  w;
        logic              typed;
        tree_edge_t        want;
    } script_row_t;

    localparam int SCRIPT_LEN = 24;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [4:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // vertex_a[3:0], vertex_b[7:4], weight[17:8], zero pad
    logic [1:0]  s_tuser;   // kind[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;   // from_vertex[3:0], to_vertex[7:4], edge_weight[17:8],
                            // running_total[31:18]
    logic        m_tlast;   // last

    logic             steady;
    int               mismatches = 0;
    int               cycles = 0;
    int               items_sent;
    logic [WGT_W-1:0] graph [MAX_VTX][MAX_VTX];
    logic [CNT_W-1:0] vertex_cnt;
    tree_edge_t       pending_edges [$];

    script_row_t script [SCRIPT_LEN] = '{
        '{ROW_CFG,  KIND_WRITE, 4'd0,  4'd0,  10'd2,    1'b0, '0},
        '{ROW_BEAT, KIND_RUN,   4'd0,  4'd0,  10'd0,    1'b1, '{4'd0, 4'd1, 10'd999, 14'd999, 1'b1}},
        '{ROW_BEAT, KIND_WRITE, 4'd0,  4'd1,  10'd0,    1'b0, '0},
        '{ROW_BEAT, KIND_RUN,   4'd15, 4'd15, 10'd1023, 1'b1, '{4'd0, 4'd1, 10'd0, 14'd0, 1'b1}},
        '{ROW_BEAT, KIND_WRITE, 4'd1,  4'd0,  10'd1023, 1'b0, '0},
        '{ROW_BEAT, KIND_RUN,   4'd0,  4'd0,  10'd0,    1'b1, '{4'd0, 4'd1, 10'd1023, 14'd1023, 1'b1}},
        '{ROW_BEAT, KIND_WRITE, 4'd15, 4'd15, 10'd1023, 1'b0, '0},
        '{ROW_BEAT, KIND_WRITE, 4'd0,  4'd15, 10'd5,    1'b0, '0},
        '{ROW_BEAT, KIND_CLEAR, 4'd15, 4'd15, 10'd1023, 1'b0, '0},
        '{ROW_BEAT, KIND_RUN,   4'd0,  4'd0,  10'd0,    1'b1, '{4'd0, 4'd1, 10'd999, 14'd999, 1'b1}},
        '{ROW_BEAT, KIND_UNUSED, 4'd15, 4'd15, 10'd1023, 1'b0, '0},
        '{ROW_CFG,  KIND_WRITE, 4'd0,  4'd0,  10'd4,    1'b0, '0},
        '{ROW_BEAT, KIND_WRITE, 4'd0,  4'd1,  10'd5,    1'b0, '0},
        '{ROW_BEAT, KIND_WRITE, 4'd0,  4'd2,  10'd5,    1'b0, '0},
        '{ROW_BEAT, KIND_WRITE, 4'd1,  4'd3,  10'd2,    1'b0, '0},
        '{ROW_BEAT, KIND_WRITE, 4'd2,  4'd3,  10'd2,    1'b0, '0},
        '{ROW_BEAT, KIND_RUN,   4'd0,  4'd0,  10'd0,    1'b0, '0},
        '{ROW_CFG,  KIND_WRITE, 4'd0,  4'd0,  10'd0,    1'b0, '0},
        '{ROW_BEAT, KIND_RUN,   4'd0,  4'd0,  10'd0,    1'b0, '0},
        '{ROW_CFG,  KIND_WRITE, 4'd0,  4'd0,  10'd1,    1'b0, '0},
        '{ROW_BEAT, KIND_RUN,   4'd0,  4'd0,  10'd0,    1'b0, '0},
        '{ROW_CFG,  KIND_WRITE, 4'd0,  4'd0,  10'd31,   1'b0, '0},
        '{ROW_BEAT, KIND_WRITE, 4'd14, 4'd15, 10'd3,    1'b0, '0},
        '{ROW_BEAT, KIND_RUN,   4'd0,  4'd0,  10'd0,    1'b0, '0}
    };

    prim_minimum_spanning_tree_unit #(
        .MAX_VERTICES(MAX_VTX)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= steady || ($urandom_range(99) >= 28);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : check_edges
        tree_edge_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_edges.size() == 0)
            begin
                report_mismatch("beat with nothing pending", m_tdata, 0);
            end
            else
            begin
                want = pending_edges.pop_front();
                if (m_tdata[3:0] != want.from_v)
                    report_mismatch("from_vertex", int'(m_tdata[3:0]), int'(want.from_v));
                if (m_tdata[7:4] != want.to_v)
                    report_mismatch("to_vertex", int'(m_tdata[7:4]), int'(want.to_v));
                if (m_tdata[17:8] != want.wgt)
                    report_mismatch("edge_weight", int'(m_tdata[17:8]), int'(want.wgt));
                if (m_tdata[31:18] != want.total)
                    report_mismatch("running_total", int'(m_tdata[31:18]), int'(want.total));
                if (m_tlast != want.last)
                    report_mismatch("last", int'(m_tlast), int'(want.last));
            end
        end
    end

    function automatic void wipe_graph();
        for (int r = 0; r < MAX_VTX; r++)
            for (int c = 0; c < MAX_VTX; c++)
                graph[r][c] = NO_EDGE;
    endfunction

    // Grow the tree from vertex 0, lowest weight first, ties to lowest tree then outside vertex.
    function automatic void grow_tree(input bit keep);
        bit         joined [MAX_VTX];
        int         n;
        int         best;
        int         total;
        int         fv;
        int         tv;
        tree_edge_t e;
        n = (vertex_cnt > MAX_VTX) ? MAX_VTX : int'(vertex_cnt);
        total = 0;
        for (int v = 0; v < MAX_VTX; v++)
            joined[v] = 1'b0;
        joined[0] = 1'b1;
        for (int step = 1; step < n; step++)
        begin
            best = int'(SCAN_START);
            fv = 0;
            tv = 0;
            for (int j = 0; j < n; j++)
            begin
                if (joined[j])
                begin
                    for (int k = 0; k < n; k++)
                    begin
                        if (!joined[k] && int'(graph[j][k]) < best)
                        begin
                            best = int'(graph[j][k]);
                            fv = j;
                            tv = k;
                        end
                    end
                end
            end
            joined[tv] = 1'b1;
            total += best;
            if (total > int'(TOTAL_MAX))
                total = int'(TOTAL_MAX);
            e.from_v = fv[VTX_W-1:0];
            e.to_v = tv[VTX_W-1:0];
            e.wgt = best[WGT_W-1:0];
            e.total = total[TOT_W-1:0];
            e.last = (step == n - 1);
            if (keep)
                pending_edges.push_back(e);
        end
    endfunction

    task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [VTX_W-1:0] va,
                             input logic [VTX_W-1:0] vb, input logic [WGT_W-1:0] w,
                             input bit keep);
        while (!steady && $urandom_range(99) < 28)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {6'd0, w, vb, va};
        do
            @(posedge clk);
        while (!s_tready);
        if (kind == KIND_WRITE)
        begin
            graph[va][vb] = w;
            graph[vb][va] = w;
        end
        else if (kind == KIND_CLEAR)
        begin
            wipe_graph();
        end
        else if (kind == KIND_RUN)
        begin
            grow_tree(keep);
        end
        if (kind != KIND_UNUSED)
            items_sent++;
    endtask

    task automatic drain_edges();
        s_tvalid <= 1'b0;
        while (pending_edges.size() != 0)
            @(posedge clk);
    endtask

    // Hold off until idle, then let any clearing pass finish before the write.
    task automatic program_vertex_count(input logic [CNT_W-1:0] value);
        drain_edges();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        vertex_cnt = value;
    endtask

    initial
    begin
        logic [CNT_W-1:0] vc_plan [12];
        logic [VTX_W-1:0] va;
        logic [VTX_W-1:0] vb;
        logic [WGT_W-1:0] w;
        int               phase;
        int               n_used;
        int               pick;

        vc_plan = '{5'd3, 5'd16, 5'd2, 5'd6, 5'd0, 5'd9, 5'd17, 5'd4, 5'd1, 5'd31, 5'd5, 5'd12};
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        steady = 1'b0;
        items_sent = 0;
        vertex_cnt = 5'd1;
        wipe_graph();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < SCRIPT_LEN; i++)
        begin
            if (script[i].row == ROW_CFG)
            begin
                program_vertex_count(script[i].w[CNT_W-1:0]);
            end
            else
            begin
                send_beat(script[i].kind, script[i].va, script[i].vb, script[i].w,
                          !script[i].typed);
                if (script[i].typed)
                    pending_edges.push_back(script[i].want);
            end
        end

        items_sent = 0;
        phase = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            steady <= (phase == 3);
            program_vertex_count(vc_plan[phase % 12]);
            n_used = (vertex_cnt > MAX_VTX) ? MAX_VTX : int'(vertex_cnt);
            repeat (2)
            begin
                if ($urandom_range(2) == 0)
                    send_beat(KIND_CLEAR, VTX_W'($urandom_range(15)),
                              VTX_W'($urandom_range(15)), WGT_W'($urandom_range(1023)),
                              1'b1);
                repeat ($urandom_range(2, 14))
                begin
                    pick = $urandom_range(99);
                    if (pick < 8)
                    begin
                        send_beat(KIND_UNUSED, VTX_W'($urandom_range(15)),
                                  VTX_W'($urandom_range(15)), WGT_W'($urandom_range(1023)),
                                  1'b1);
                    end
                    else if (pick < 12)
                    begin
                        send_beat(KIND_CLEAR, VTX_W'($urandom_range(15)),
                                  VTX_W'($urandom_range(15)), WGT_W'($urandom_range(1023)),
                                  1'b1);
                    end
                    else
                    begin
                        if (pick < 22 || n_used < 2)
                        begin
                            va = VTX_W'($urandom_range(15));
                            vb = VTX_W'($urandom_range(15));
                        end
                        else
                        begin
                            va = VTX_W'($urandom_range(n_used - 1));
                            vb = VTX_W'($urandom_range(n_used - 1));
                        end
                        case ($urandom_range(9))
                            0, 1, 2, 3: w = WGT_W'($urandom_range(1, 4));
                            4, 5, 6:    w = WGT_W'($urandom_range(1023));
                            7:          w = '0;
                            8:          w = '1;
                            default:    w = NO_EDGE;
                        endcase
                        send_beat(KIND_WRITE, va, vb, w, 1'b1);
                    end
                end
                send_beat(KIND_RUN, VTX_W'($urandom_range(15)), VTX_W'($urandom_range(15)),
                          WGT_W'($urandom_range(1023)), 1'b1);
                if ($urandom_range(3) == 0)
                    drain_edges();
            end
            phase++;
        end

        drain_edges();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_edges.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/pmst_pkg.sv
rtl/core/pmst_ram.sv
rtl/core/pmst_seq.sv
rtl/core/pmst_datapath.sv
rtl/core/prim_minimum_spanning_tree_unit.sv
tb/sv/tb_top.sv
